[rtl/core/lrf_pkg.sv]
// ----------------------------------------------------------------------------
// lrf_pkg
// Shared types and constants of the line raster framebuffer.
// ----------------------------------------------------------------------------
package lrf_pkg;

  localparam int DEF_MAX_WIDTH  = 256;
  localparam int DEF_MAX_HEIGHT = 256;
  localparam int CMD_FIFO_DEPTH = 2;
  localparam int CNT_W          = 17;
  localparam int FB_REG_W       = 9;
  localparam int CFG_IDX_W      = 2;

  localparam logic [FB_REG_W-1:0]  FB_REG_RESET  = 9'd256;
  localparam logic [CFG_IDX_W-1:0] REG_FB_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FB_HEIGHT = 2'd1;

  typedef enum logic [1:0] {
    FN_PLOT  = 2'd0,
    FN_LINE  = 2'd1,
    FN_CLEAR = 2'd2,
    FN_READ  = 2'd3
  } func_e;

  // classified command, line setup already done
  typedef struct packed {
    func_e              func;
    logic               in_area;
    logic               x_major;
    logic               empty;
    logic [15:0]        px;
    logic [15:0]        py;
    logic [15:0]        lo;
    logic [15:0]        steps;
    logic signed [17:0] s_min;
    logic [16:0]        a_min;
    logic               m_neg;
    logic [16:0]        d_maj;
    logic [15:0]        off0;
    logic [31:0]        color;
  } lrf_cmd_t;

endpackage

[rtl/core/line_raster_framebuffer.sv]
// ----------------------------------------------------------------------------
// line_raster_framebuffer
// RGBA framebuffer with plot, line, clear and read commands.
//
//   channel   dir  handshake                tdata / tuser
//   s_axis    in   s_axis_tvalid/tready     command item
//   m_axis    out  m_axis_tvalid/tready     result item
//   cfg       in   cfg_we_i                 fb_width (0), fb_height (1)
//
// Clear writes width*height store entries, one store write per cycle; a
// line runs a 33-step divider for the start offset, then one pixel per cycle;
// a read passes through S_RD1 and S_RD2; an outside read or a line with
// nothing visible goes straight to the final state. The 2-entry queue
// lets the front accept while the back works; a stalled result holds the back
// in its final state. Reset restores both size registers to 256; pixel store
// contents are undefined until written.
// ----------------------------------------------------------------------------
module line_raster_framebuffer import lrf_pkg::*; #(
  parameter int  MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int  MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [95:0]          s_axis_tdata,  // x_start, y_start, x_end, y_end, color
  input  logic [1:0]           s_axis_tuser,  // func
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [55:0]          m_axis_tdata,  // read_data, pixels_written, zero pad
  output logic [0:0]           m_axis_tuser,  // out_of_range
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [FB_REG_W-1:0]  cfg_data_i
);

  localparam int CW = $clog2(((MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT) + 1);

  logic [FB_REG_W-1:0] fb_width_q, fb_height_q;
  logic [CW-1:0]       aw, ah;
  logic                push, full, pop, q_valid;
  lrf_cmd_t            cmd_in, cmd_out;
  logic [31:0]         read_data;
  logic [CNT_W-1:0]    pixels_written;
  logic                out_of_range;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fb_width_q  <= FB_REG_RESET;
      fb_height_q <= FB_REG_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_FB_WIDTH:  fb_width_q  <= cfg_data_i;
        REG_FB_HEIGHT: fb_height_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign aw = (int'(fb_width_q) > MAX_WIDTH) ? CW'(MAX_WIDTH) : CW'(fb_width_q);
  assign ah = (int'(fb_height_q) > MAX_HEIGHT) ? CW'(MAX_HEIGHT) : CW'(fb_height_q);

  lrf_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .valid_i   (s_axis_tvalid),
    .ready_o   (s_axis_tready),
    .func_i    (s_axis_tuser),
    .x_start_i (s_axis_tdata[15:0]),
    .y_start_i (s_axis_tdata[31:16]),
    .x_end_i   (s_axis_tdata[47:32]),
    .y_end_i   (s_axis_tdata[63:48]),
    .color_i   (s_axis_tdata[95:64]),
    .aw_i      (aw),
    .ah_i      (ah),
    .full_i    (full),
    .push_o    (push),
    .cmd_o     (cmd_in)
  );

  lrf_fifo #(
    .DEPTH (CMD_FIFO_DEPTH)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (cmd_in),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .cmd_o   (cmd_out)
  );

  lrf_back #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_valid_i      (q_valid),
    .cmd_i            (cmd_out),
    .cmd_pop_o        (pop),
    .aw_i             (aw),
    .ah_i             (ah),
    .out_valid_o      (m_axis_tvalid),
    .out_ready_i      (m_axis_tready),
    .read_data_o      (read_data),
    .pixels_written_o (pixels_written),
    .out_of_range_o   (out_of_range)
  );

  assign m_axis_tdata = {7'd0, pixels_written, read_data};
  assign m_axis_tuser = out_of_range;

endmodule

[rtl/core/lrf_front.sv]
// ----------------------------------------------------------------------------
// lrf_front
// Accepts commands, clips points and sets up line geometry for the queue.
// ----------------------------------------------------------------------------
module lrf_front import lrf_pkg::*; #(
  parameter int  MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int  MAX_HEIGHT = DEF_MAX_HEIGHT,
  localparam int CW = $clog2(((MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT) + 1)
) (
  input  logic               valid_i,
  output logic               ready_o,
  input  logic [1:0]         func_i,
  input  logic signed [15:0] x_start_i,
  input  logic signed [15:0] y_start_i,
  input  logic signed [15:0] x_end_i,
  input  logic signed [15:0] y_end_i,
  input  logic [31:0]        color_i,
  input  logic [CW-1:0]      aw_i,
  input  logic [CW-1:0]      ah_i,
  input  logic               full_i,
  output logic               push_o,
  output lrf_cmd_t           cmd_o
);

  logic signed [16:0] dx, dy, d_min, d_maj, s_maj, e_maj, s_min, sm_x, em_x;
  logic signed [16:0] lo, hi, lim_s, aw_s, ah_s;
  logic [16:0]        adx, ady;
  logic               x_major, neg;
  logic [CW-1:0]      lim;

  assign ready_o = !full_i;
  assign push_o  = valid_i && !full_i;

  always_comb begin
    dx      = $signed(x_end_i) - $signed(x_start_i);
    dy      = $signed(y_end_i) - $signed(y_start_i);
    adx     = dx[16] ? 17'(-dx) : 17'(dx);
    ady     = dy[16] ? 17'(-dy) : 17'(dy);
    x_major = adx > ady;
    s_maj   = x_major ? $signed({x_start_i[15], x_start_i}) : $signed({y_start_i[15], y_start_i});
    e_maj   = x_major ? $signed({x_end_i[15], x_end_i}) : $signed({y_end_i[15], y_end_i});
    s_min   = x_major ? $signed({y_start_i[15], y_start_i}) : $signed({x_start_i[15], x_start_i});
    d_min   = x_major ? dy : dx;
    d_maj   = x_major ? dx : dy;
    neg     = d_maj[16];
    sm_x    = neg ? e_maj : s_maj;
    em_x    = neg ? s_maj : e_maj;
    lim     = x_major ? aw_i : ah_i;
    lim_s   = $signed(17'(lim));
    aw_s    = $signed(17'(aw_i));
    ah_s    = $signed(17'(ah_i));
    lo      = sm_x[16] ? 17'sd0 : sm_x;
    hi      = (em_x < lim_s) ? em_x : lim_s;

    cmd_o         = '0;
    cmd_o.func    = func_e'(func_i);
    cmd_o.color   = color_i;
    cmd_o.px      = x_start_i;
    cmd_o.py      = y_start_i;
    cmd_o.in_area = !x_start_i[15] && !y_start_i[15] &&
                    ($signed({x_start_i[15], x_start_i}) < aw_s) &&
                    ($signed({y_start_i[15], y_start_i}) < ah_s);
    cmd_o.x_major = x_major;
    cmd_o.empty   = !(lo < hi);
    cmd_o.lo      = lo[15:0];
    cmd_o.steps   = 16'(hi - lo);
    cmd_o.off0    = 16'(lo - sm_x);
    cmd_o.s_min   = neg ? ($signed({s_min[16], s_min}) + $signed({d_min[16], d_min}))
                        : $signed({s_min[16], s_min});
    cmd_o.a_min   = d_min[16] ? 17'(-d_min) : 17'(d_min);
    cmd_o.m_neg   = neg ? (!d_min[16] && (d_min != 17'sd0)) : d_min[16];
    cmd_o.d_maj   = neg ? 17'(-d_maj) : 17'(d_maj);
  end

endmodule

[rtl/core/lrf_fifo.sv]
// ----------------------------------------------------------------------------
// lrf_fifo
// Short command queue between the front and the back.
// ----------------------------------------------------------------------------
module lrf_fifo import lrf_pkg::*; #(
  parameter int  DEPTH = CMD_FIFO_DEPTH,
  localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int NW    = $clog2(DEPTH + 1)
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  input  lrf_cmd_t cmd_i,
  output logic     full_o,
  input  logic     pop_i,
  output logic     valid_o,
  output lrf_cmd_t cmd_o
);

  lrf_cmd_t      mem_q [DEPTH];
  logic [PW-1:0] wr_q, rd_q;
  logic [NW-1:0] cnt_q;

  assign full_o  = (cnt_q == NW'(DEPTH));
  assign valid_o = (cnt_q != '0);
  assign cmd_o   = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
      end
      if (pop_i) begin
        rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (!push_i && pop_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

[rtl/core/lrf_back.sv]
// ----------------------------------------------------------------------------
// lrf_back
// Executes commands: pixel store, line stepping with divider, clear, read.
// ----------------------------------------------------------------------------
module lrf_back import lrf_pkg::*; #(
  parameter int  MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int  MAX_HEIGHT = DEF_MAX_HEIGHT,
  localparam int CW    = $clog2(((MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT) + 1),
  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int NW    = $clog2(DEPTH + 1)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cmd_valid_i,
  input  lrf_cmd_t          cmd_i,
  output logic              cmd_pop_o,
  input  logic [CW-1:0]     aw_i,
  input  logic [CW-1:0]     ah_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [31:0]       read_data_o,
  output logic [CNT_W-1:0]  pixels_written_o,
  output logic              out_of_range_o
);

  typedef enum logic [2:0] {
    S_IDLE, S_MUL, S_DIV, S_LINE, S_CLR, S_RD1, S_RD2, S_FIN
  } state_e;

  state_e             state_q;
  lrf_cmd_t           cmd_q;
  logic [32:0]        prod_q;
  logic [17:0]        rem_q;
  logic [5:0]         div_cnt_q;
  logic [CW-1:0]      m_q, left_q;
  logic [CNT_W-1:0]   cnt_q;
  logic [NW-1:0]      clr_q, clr_n_q;
  logic [31:0]        res_data_q;
  logic [CNT_W-1:0]   res_cnt_q;
  logic               res_oor_q;
  logic               out_valid_q;
  logic [31:0]        out_data_q;
  logic [CNT_W-1:0]   out_cnt_q;
  logic               out_oor_q;
  logic               a_v_q, a_rd_q;
  logic [CW-1:0]      a_x_q, a_y_q;
  logic [31:0]        a_color_q;

  logic [31:0]        mem [DEPTH];
  logic [31:0]        rd_data_q;

  logic [17:0]        rem_sh, r_sum;
  logic               ge;
  logic signed [18:0] mn;
  logic [CW-1:0]      lim_min;
  logic               mn_in;
  logic [2*CW-1:0]    pix_sum;
  logic [AW-1:0]      pix_addr, wr_addr;
  logic               wr_en, clr_we;
  logic [31:0]        wr_data;
  logic               fin_go;

  assign cmd_pop_o        = (state_q == S_IDLE) && cmd_valid_i;
  assign out_valid_o      = out_valid_q;
  assign read_data_o      = out_data_q;
  assign pixels_written_o = out_cnt_q;
  assign out_of_range_o   = out_oor_q;

  always_comb begin
    rem_sh  = {rem_q[16:0], prod_q[32]};
    ge      = rem_sh >= {1'b0, cmd_q.d_maj};
    r_sum   = {1'b0, rem_q[16:0]} + {1'b0, cmd_q.a_min};
    mn      = cmd_q.m_neg ? ($signed({cmd_q.s_min[17], cmd_q.s_min}) - $signed({2'b00, prod_q[16:0]}))
                          : ($signed({cmd_q.s_min[17], cmd_q.s_min}) + $signed({2'b00, prod_q[16:0]}));
    lim_min = cmd_q.x_major ? ah_i : aw_i;
    mn_in   = !mn[18] && (mn < $signed(19'(lim_min)));
    pix_sum = a_y_q * aw_i + (2*CW)'(a_x_q);
    pix_addr = AW'(pix_sum);
    clr_we  = (state_q == S_CLR) && (clr_q != clr_n_q);
    wr_en   = clr_we || (a_v_q && !a_rd_q);
    wr_addr = clr_we ? AW'(clr_q) : pix_addr;
    wr_data = clr_we ? cmd_q.color : a_color_q;
    fin_go  = (state_q == S_FIN) && (!out_valid_q || out_ready_i);
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_q <= mem[pix_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cmd_q       <= '0;
      prod_q      <= '0;
      rem_q       <= '0;
      div_cnt_q   <= '0;
      m_q         <= '0;
      left_q      <= '0;
      cnt_q       <= '0;
      clr_q       <= '0;
      clr_n_q     <= '0;
      res_data_q  <= '0;
      res_cnt_q   <= '0;
      res_oor_q   <= 1'b0;
      out_valid_q <= 1'b0;
      out_data_q  <= '0;
      out_cnt_q   <= '0;
      out_oor_q   <= 1'b0;
      a_v_q       <= 1'b0;
      a_rd_q      <= 1'b0;
      a_x_q       <= '0;
      a_y_q       <= '0;
      a_color_q   <= '0;
    end else begin
      if ((state_q != S_IDLE) && (state_q != S_LINE)) begin
        a_v_q <= 1'b0;
      end
      if (fin_go) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          a_v_q <= cmd_valid_i && (cmd_i.func == FN_PLOT) && cmd_i.in_area;
          if (cmd_valid_i) begin
            cmd_q      <= cmd_i;
            cnt_q      <= '0;
            res_data_q <= '0;
            a_x_q      <= cmd_i.px[CW-1:0];
            a_y_q      <= cmd_i.py[CW-1:0];
            a_color_q  <= cmd_i.color;
            case (cmd_i.func)
              FN_PLOT: begin
                a_rd_q    <= 1'b0;
                res_cnt_q <= CNT_W'(cmd_i.in_area);
                res_oor_q <= !cmd_i.in_area;
                state_q   <= S_FIN;
              end
              FN_READ: begin
                a_rd_q    <= 1'b1;
                res_cnt_q <= '0;
                res_oor_q <= !cmd_i.in_area;
                state_q   <= cmd_i.in_area ? S_RD1 : S_FIN;
              end
              FN_LINE: begin
                res_cnt_q <= '0;
                res_oor_q <= 1'b0;
                state_q   <= cmd_i.empty ? S_FIN : S_MUL;
              end
              FN_CLEAR: begin
                res_cnt_q <= '0;
                res_oor_q <= 1'b0;
                clr_q     <= '0;
                clr_n_q   <= NW'(aw_i * ah_i);
                state_q   <= S_CLR;
              end
              default: begin
                res_cnt_q <= '0;
                res_oor_q <= 1'b0;
                state_q   <= S_FIN;
              end
            endcase
          end
        end
        S_MUL: begin
          prod_q    <= cmd_q.a_min * cmd_q.off0;
          rem_q     <= '0;
          div_cnt_q <= '0;
          state_q   <= S_DIV;
        end
        S_DIV: begin
          rem_q     <= ge ? (rem_sh - {1'b0, cmd_q.d_maj}) : rem_sh;
          prod_q    <= {prod_q[31:0], ge};
          div_cnt_q <= div_cnt_q + 1'b1;
          if (div_cnt_q == 6'd32) begin
            m_q     <= cmd_q.lo[CW-1:0];
            left_q  <= cmd_q.steps[CW-1:0];
            state_q <= S_LINE;
          end
        end
        S_LINE: begin
          a_v_q     <= mn_in;
          a_rd_q    <= 1'b0;
          a_x_q     <= cmd_q.x_major ? m_q : mn[CW-1:0];
          a_y_q     <= cmd_q.x_major ? mn[CW-1:0] : m_q;
          a_color_q <= cmd_q.color;
          cnt_q     <= cnt_q + CNT_W'(mn_in);
          if (r_sum >= {1'b0, cmd_q.d_maj}) begin
            rem_q  <= r_sum - {1'b0, cmd_q.d_maj};
            prod_q <= prod_q + 33'd1;
          end else begin
            rem_q <= r_sum;
          end
          m_q    <= m_q + 1'b1;
          left_q <= left_q - 1'b1;
          if (left_q == CW'(1)) begin
            res_cnt_q <= cnt_q + CNT_W'(mn_in);
            state_q   <= S_FIN;
          end
        end
        S_CLR: begin
          if (clr_q == clr_n_q) begin
            res_cnt_q <= CNT_W'(clr_n_q);
            state_q   <= S_FIN;
          end else begin
            clr_q <= clr_q + 1'b1;
          end
        end
        S_RD1: state_q <= S_RD2;
        S_RD2: begin
          res_data_q <= rd_data_q;
          state_q    <= S_FIN;
        end
        S_FIN: begin
          if (fin_go) begin
            out_data_q <= res_data_q;
            out_cnt_q  <= res_cnt_q;
            out_oor_q  <= res_oor_q;
            state_q    <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

[bench/tb_line_raster_framebuffer.sv]
// ----------------------------------------------------------------------------
// tb_line_raster_framebuffer
// Drives plot, line, clear and read commands through the stream port with
// random gaps and stalls on both sides. A shadow pixel store predicts every
// result; each result transfer is compared field by field in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_line_raster_framebuffer import lrf_pkg::*; ();

  localparam int MW = 256;
  localparam int MH = 256;
  localparam longint CYCLE_LIMIT = 64'd40_000_000;

  typedef struct packed {
    logic [31:0] read_data;
    logic [16:0] pixels_written;
    logic        out_of_range;
  } fb_result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [95:0] s_axis_tdata = '0;
  logic [1:0] s_axis_tuser = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [55:0] m_axis_tdata;
  logic [0:0] m_axis_tuser;
  logic cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [FB_REG_W-1:0] cfg_data_i = '0;

  line_raster_framebuffer dut (.*);

  logic [31:0] shadow_fb [MW*MH];
  bit          shadow_written [MW*MH];
  int unsigned width_reg, height_reg;
  fb_result_t  pending_results [$];
  int          errors = 0;
  int          n_results = 0;
  int          n_cmds = 0;
  longint      cycles = 0;
  bit          quiet_rx = 0;
  int          hold_off = 0;

  initial forever #2 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  function automatic int unsigned act_w();
    return width_reg > MW ? MW : width_reg;
  endfunction

  function automatic int unsigned act_h();
    return height_reg > MH ? MH : height_reg;
  endfunction

  function automatic bit in_area(longint x, longint y);
    return x >= 0 && y >= 0 && x < act_w() && y < act_h();
  endfunction

  function automatic int unsigned put_pixel(longint x, longint y, logic [31:0] c);
    int unsigned idx;
    if (!in_area(x, y)) return 0;
    idx = int'(y) * act_w() + int'(x);
    shadow_fb[idx] = c;
    shadow_written[idx] = 1;
    return 1;
  endfunction

  function automatic int unsigned raster_line(longint xa, longint ya, longint xb,
                                              longint yb, logic [31:0] c);
    longint dx, dy, smj, emj, smn, dmj, dmn, lim, lo, hi, mn, t;
    bit xm;
    int unsigned cnt;
    dx = xb - xa;
    dy = yb - ya;
    xm = (dx < 0 ? -dx : dx) > (dy < 0 ? -dy : dy);
    cnt = 0;
    if (xm) begin
      smj = xa; emj = xb; smn = ya; dmj = dx; dmn = dy; lim = act_w();
    end else begin
      smj = ya; emj = yb; smn = xa; dmj = dy; dmn = dx; lim = act_h();
    end
    if (dmj < 0) begin
      t = smj; smj = emj; emj = t;
      smn = smn + dmn; dmj = -dmj; dmn = -dmn;
    end
    if (dmj == 0) return 0;
    lo = smj < 0 ? 0 : smj;
    hi = emj < lim ? emj : lim;
    for (longint m = lo; m < hi; m++) begin
      mn = smn + (dmn * (m - smj)) / dmj;
      cnt += xm ? put_pixel(m, mn, c) : put_pixel(mn, m, c);
    end
    return cnt;
  endfunction

  // predicted result of one command, shadow store updated
  function automatic fb_result_t predict_cmd(func_e fn, logic signed [15:0] xs,
      logic signed [15:0] ys, logic signed [15:0] xe, logic signed [15:0] ye,
      logic [31:0] c);
    fb_result_t r;
    int unsigned n, cnt;
    r = '0;
    case (fn)
      FN_PLOT: begin
        cnt = put_pixel(longint'(xs), longint'(ys), c);
        r.pixels_written = cnt[16:0];
        r.out_of_range = (cnt == 0);
      end
      FN_LINE: begin
        cnt = raster_line(longint'(xs), longint'(ys), longint'(xe), longint'(ye), c);
        r.pixels_written = cnt[16:0];
      end
      FN_CLEAR: begin
        n = act_w() * act_h();
        for (int i = 0; i < n; i++) begin
          shadow_fb[i] = c;
          shadow_written[i] = 1;
        end
        r.pixels_written = n[16:0];
      end
      default: begin
        if (in_area(longint'(xs), longint'(ys)))
          r.read_data = shadow_fb[int'(ys) * act_w() + int'(xs)];
        else r.out_of_range = 1;
      end
    endcase
    return r;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    errors++;
    $display("mismatch result %0d %s: got %0h want %0h", n_results, what, got, want);
  endtask

  // result side: random stall, plus long hold-off on request
  always @(posedge clk_i) begin
    if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= quiet_rx ? 1'b1 : ($urandom_range(99) >= 9);
    end
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      fb_result_t want;
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected transfer", longint'(m_axis_tdata), 0);
      end else begin
        want = pending_results.pop_front();
        if (m_axis_tdata[31:0] !== want.read_data)
          report_mismatch("read_data", longint'(m_axis_tdata[31:0]),
                          longint'(want.read_data));
        if (m_axis_tdata[48:32] !== want.pixels_written)
          report_mismatch("pixels_written", longint'(m_axis_tdata[48:32]),
                          longint'(want.pixels_written));
        if (m_axis_tdata[55:49] !== '0)
          report_mismatch("pad", longint'(m_axis_tdata[55:49]), 0);
        if (m_axis_tuser[0] !== want.out_of_range)
          report_mismatch("out_of_range", longint'(m_axis_tuser[0]),
                          longint'(want.out_of_range));
      end
      n_results++;
    end
  end

  task automatic send_cmd(func_e fn, logic signed [15:0] xs, logic signed [15:0] ys,
                          logic signed [15:0] xe, logic signed [15:0] ye,
                          logic [31:0] c, bit no_gap = 0);
    while (!no_gap && !quiet_rx && $urandom_range(99) < 9) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= fn;
    s_axis_tdata <= {c, ye, xe, ys, xs};
    pending_results.push_back(predict_cmd(fn, xs, ys, xe, ye, c));
    n_cmds++;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int unsigned val);
    drain();
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val[FB_REG_W-1:0];
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == REG_FB_WIDTH) width_reg = val & 9'h1ff;
    if (idx == REG_FB_HEIGHT) height_reg = val & 9'h1ff;
  endtask

  task automatic set_geometry(int unsigned w, int unsigned h);
    write_reg(REG_FB_WIDTH, w);
    write_reg(REG_FB_HEIGHT, h);
    // the store layout changes: forget what was written
    for (int i = 0; i < MW*MH; i++) shadow_written[i] = 0;
  endtask

  function automatic logic signed [15:0] rnd_coord(int unsigned span);
    if ($urandom_range(9) == 0) return 16'($urandom);
    return 16'($signed($urandom_range(span + 8)) - 4);
  endfunction

  // read only known entries, or outside points
  task automatic safe_read(logic signed [15:0] x, logic signed [15:0] y);
    if (in_area(longint'(x), longint'(y)) && !shadow_written[int'(y) * act_w() + int'(x)])
      x = -1;
    send_cmd(FN_READ, x, y, 0, 0, $urandom);
  endtask

  task automatic test_directed();
    send_cmd(FN_CLEAR, 0, 0, 0, 0, 32'h0);
    send_cmd(FN_PLOT, 0, 0, 0, 0, 32'hffff_ffff);
    send_cmd(FN_PLOT, 255, 255, 0, 0, 32'h1234_5678);
    send_cmd(FN_PLOT, -32768, 32767, 0, 0, 32'h1);
    send_cmd(FN_PLOT, 256, 0, 0, 0, 32'h2);
    safe_read(0, 0);
    safe_read(255, 255);
    safe_read(32767, -32768);
    send_cmd(FN_LINE, 10, 10, 10, 10, 32'h3);
    send_cmd(FN_LINE, 0, 0, 20, 20, 32'h4);
    send_cmd(FN_LINE, 200, 5, 3, 40, 32'h5);
    send_cmd(FN_LINE, 5, 200, 40, 3, 32'h6);
    send_cmd(FN_LINE, -32768, -32768, 32767, 32767, 32'h7);
    send_cmd(FN_LINE, 32767, 100, -32768, 120, 32'h8);
    send_cmd(FN_LINE, -300, 0, 300, -5, 32'h9);
    safe_read(100, 100);
    safe_read(20, 20);
    safe_read(0, 5);
  endtask

  task automatic test_geometry_edges();
    set_geometry(0, 0);
    send_cmd(FN_PLOT, 0, 0, 0, 0, 32'haa);
    send_cmd(FN_CLEAR, 0, 0, 0, 0, 32'hbb);
    send_cmd(FN_LINE, 0, 0, 9, 3, 32'hcc);
    safe_read(0, 0);
    set_geometry(511, 300);
    send_cmd(FN_CLEAR, 0, 0, 0, 0, 32'hdead_beef);
    safe_read(255, 255);
    set_geometry(1, 256);
    send_cmd(FN_CLEAR, 0, 0, 0, 0, 32'h55);
    send_cmd(FN_LINE, 0, -4, 0, 300, 32'h66);
    safe_read(0, 100);
  endtask

  task automatic random_phase(int count, int unsigned w, int unsigned h);
    int k;
    set_geometry(w, h);
    send_cmd(FN_CLEAR, 0, 0, 0, 0, $urandom);
    for (int i = 0; i < count; i++) begin
      k = $urandom_range(99);
      if (k < 30) send_cmd(FN_PLOT, rnd_coord(act_w()), rnd_coord(act_h()), 16'($urandom),
                           16'($urandom), $urandom);
      else if (k < 60) send_cmd(FN_LINE, rnd_coord(act_w()), rnd_coord(act_h()),
                                rnd_coord(act_w()), rnd_coord(act_h()), $urandom);
      else if (k < 62) send_cmd(FN_CLEAR, 16'($urandom), 16'($urandom), 16'($urandom),
                                16'($urandom), $urandom);
      else safe_read(rnd_coord(act_w()), rnd_coord(act_h()));
    end
  endtask

  task automatic test_backpressure();
    hold_off = 400;
    for (int i = 0; i < 8; i++) send_cmd(FN_PLOT, 16'(i), 16'(i), 0, 0, $urandom, 1);
    drain();
    for (int i = 0; i < 4; i++) safe_read(16'(i), 16'(i));
  endtask

  initial begin
    width_reg = 256;
    height_reg = 256;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_geometry_edges();
    test_backpressure();
    random_phase(350, 16, 12);
    random_phase(300, 7, 33);
    quiet_rx = 1;
    random_phase(200, 40, 5);
    quiet_rx = 0;
    random_phase(300, 256, 256);
    random_phase(200, 1, 1);
    drain();
    repeat (200) @(posedge clk_i);
    $display("%0d commands sent, %0d results checked over several geometries,",
             n_cmds, n_results);
    $display("including zero, oversized and single-pixel areas and a long output stall");
    if (errors == 0 && pending_results.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end
endmodule
